### rtl/core/i2cbm_pkg.sv
// package for the bit-level i2c master: codes, phase encodings and the
// structs shared by the config, step and top-level modules
// no dependencies
package i2cbm_pkg;

    localparam logic [2:0] FUNC_NONE  = 3'd0;
    localparam logic [2:0] FUNC_START = 3'd1;
    localparam logic [2:0] FUNC_STOP  = 3'd2;
    localparam logic [2:0] FUNC_WRITE = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;
    localparam logic [2:0] FUNC_WAIT  = 3'd5;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ST1     = 4'd1;
    localparam logic [3:0] PH_ST2     = 4'd2;
    localparam logic [3:0] PH_SP1     = 4'd3;
    localparam logic [3:0] PH_SP2     = 4'd4;
    localparam logic [3:0] PH_SP3     = 4'd5;
    localparam logic [3:0] PH_WR_SET  = 4'd6;
    localparam logic [3:0] PH_WR_HIGH = 4'd7;
    localparam logic [3:0] PH_WR_LOW  = 4'd8;
    localparam logic [3:0] PH_RD_LOW  = 4'd9;
    localparam logic [3:0] PH_RD_HIGH = 4'd10;
    localparam logic [3:0] PH_AK_LOW  = 4'd11;
    localparam logic [3:0] PH_AK_HIGH = 4'd12;
    localparam logic [3:0] PH_WA1     = 4'd13;
    localparam logic [3:0] PH_WA2     = 4'd14;
    localparam logic [3:0] PH_WA_POLL = 4'd15;

    localparam int          BITS_PER_BYTE = 8;
    localparam logic [3:0]  LAST_BIT      = 4'(BITS_PER_BYTE);

    localparam logic        REG_UNIT_TICKS  = 1'b0;
    localparam logic        REG_ACK_TIMEOUT = 1'b1;
    localparam logic [15:0] UNIT_TICKS_RST  = 16'd50;
    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

    typedef struct packed {
        logic [15:0] unit_ticks;
        logic [7:0]  ack_timeout;
    } cfg_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] wr_data;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic [3:0]  bit_index;
        logic [7:0]  shift_byte;
        logic [17:0] delay_count;
        logic [7:0]  timeout_count;
        logic        scl_level;
        logic        sda_level;
        logic        sda_dir;
        logic        ack_choice;
        logic [7:0]  last_rd;
        logic        miss_flag;
    } state_t;

    // idle bus, scl and sda high and driven
    localparam state_t STATE_RST = '{
        phase: PH_IDLE, bit_index: 4'd0, shift_byte: 8'd0, delay_count: 18'd0,
        timeout_count: 8'd0, scl_level: 1'b1, sda_level: 1'b1, sda_dir: 1'b1,
        ack_choice: 1'b0, last_rd: 8'd0, miss_flag: 1'b0
    };

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_data;
        logic       ack_missing;
        logic       cmd_ignored;
    } res_t;

endpackage

### rtl/core/i2c_bit_level_master_unit.sv
// Bit-level timed i2c master. Each input transaction on the s_ channel is one
// tick of the bus timer and may carry a command (start, stop, write byte,
// read byte with ack or nack, wait for slave ack); each tick produces exactly
// one result transaction on the m_ channel with the scl/sda levels, the sda
// direction, a busy level and a done pulse, the last read byte and the error flags.
// Holds last a multiple of unit_ticks ticks; ack_timeout bounds the wait ack.
// Both are written through the apb port at 0x0 and 0x4; the user must write
// them only while idle, the block itself does not enforce it. An accepted
// transaction is held in the input register; the step logic updates the
// state and loads the result register from it. Throughput is one
// transaction per cycle while the m_ channel does not stall.
// A stalled m_ channel holds the result register; the input register fills
// and s_tready drops until the result is taken. No tick is lost or repeated.
// Reset (aresetn low, synchronous) returns the bus to idle with scl and sda
// high and driven, clears the flags and restores the register defaults.
// Depends on i2cbm_pkg, i2cbm_cfg and i2cbm_step.
module i2c_bit_level_master_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // wr_data[7:0], send_ack[8], sda_in[9], zero pad
    input  logic [2:0]  s_tuser,   // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // scl_out[0], sda_out[1], sda_drive[2], busy_res[3],
                                   // done_res[4], rd_data[12:5], ack_missing[13],
                                   // cmd_ignored[14], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2cbm_pkg::*;

    cfg_t   cfg;
    item_t  item_reg;
    logic   in_valid_reg;
    logic   in_valid_next;
    state_t state_reg;
    state_t state_next;
    res_t   res;
    res_t   res_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   s_accept;
    logic   adv;

    i2cbm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2cbm_step u_step (
        .cfg     (cfg),
        .item    (item_reg),
        .st      (state_reg),
        .st_next (state_next),
        .res     (res)
    );

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (adv ? 1'b0 : in_valid_reg);
    assign out_valid_next = adv ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RST;
        end else if (adv) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= '{func: s_tuser, wr_data: s_tdata[7:0], send_ack: s_tdata[8],
                          sda_in: s_tdata[9]};
        end
        if (adv) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_reg.cmd_ignored, res_reg.ack_missing, res_reg.rd_data,
                       res_reg.done_res, res_reg.busy_res, res_reg.sda_drive,
                       res_reg.sda_out, res_reg.scl_out};

    a_idle_no_delay: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_IDLE) |-> (state_reg.delay_count == '0))
        else $error("idle phase with a pending hold");

    a_bit_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.bit_index <= LAST_BIT)
        else $error("bit index beyond one byte");

    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && res.done_res) |=> (state_reg.phase == PH_IDLE))
        else $error("done pulse without return to idle");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with empty input register");

    a_state_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(state_reg))
        else $error("state changed without a processed transaction");

endmodule

### rtl/core/i2cbm_cfg.sv
// apb register file holding unit_ticks and ack_timeout
// depends on i2cbm_pkg
module i2cbm_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output i2cbm_pkg::cfg_t     cfg
);
    import i2cbm_pkg::*;

    logic [15:0] unit_ticks_reg;
    logic [7:0]  ack_timeout_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_ticks_reg  <= UNIT_TICKS_RST;
            ack_timeout_reg <= ACK_TIMEOUT_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_UNIT_TICKS:  unit_ticks_reg  <= pwdata[15:0];
                REG_ACK_TIMEOUT: ack_timeout_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_UNIT_TICKS:  prdata = {16'd0, unit_ticks_reg};
            REG_ACK_TIMEOUT: prdata = {24'd0, ack_timeout_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.unit_ticks  = unit_ticks_reg;
    assign cfg.ack_timeout = ack_timeout_reg;

endmodule

### rtl/core/i2cbm_step.sv
// one-tick next-state and result logic of the bit-level i2c master
// depends on i2cbm_pkg
module i2cbm_step (
    input  i2cbm_pkg::cfg_t   cfg,
    input  i2cbm_pkg::item_t  item,
    input  i2cbm_pkg::state_t st,
    output i2cbm_pkg::state_t st_next,
    output i2cbm_pkg::res_t   res
);
    import i2cbm_pkg::*;

    logic [17:0] hold1;
    logic [17:0] hold2;
    logic [17:0] hold4;
    logic [2:0]  cmd;
    logic [17:0] dc;
    logic [3:0]  bi;
    logic [7:0]  sb;
    logic        done;
    logic        ignored;
    state_t      n;

    assign hold1 = {2'b00, cfg.unit_ticks};
    assign hold2 = {1'b0, cfg.unit_ticks, 1'b0};
    assign hold4 = {cfg.unit_ticks, 2'b00};
    assign cmd   = (item.func > FUNC_WAIT) ? FUNC_NONE : item.func;

    always_comb begin
        n       = st;
        done    = 1'b0;
        ignored = 1'b0;
        dc      = '0;
        bi      = st.bit_index + 4'd1;
        sb      = '0;
        if (st.phase != PH_IDLE) begin
            ignored = (cmd != FUNC_NONE);
            dc = (st.delay_count != '0) ? st.delay_count - 18'd1 : '0;
            n.delay_count = dc;
            if (dc == '0) begin
                case (st.phase)
                    PH_ST1: begin
                        n.sda_level = 1'b0; n.delay_count = hold4; n.phase = PH_ST2;
                    end
                    PH_ST2: begin
                        n.scl_level = 1'b0; n.phase = PH_IDLE; done = 1'b1;
                    end
                    PH_SP1: begin
                        n.scl_level = 1'b1; n.delay_count = hold4; n.phase = PH_SP2;
                    end
                    PH_SP2: begin
                        n.sda_level = 1'b1; n.delay_count = hold4; n.phase = PH_SP3;
                    end
                    PH_WR_SET: begin
                        n.scl_level = 1'b1; n.delay_count = hold2; n.phase = PH_WR_HIGH;
                    end
                    PH_WR_HIGH: begin
                        n.scl_level = 1'b0; n.delay_count = hold2; n.phase = PH_WR_LOW;
                    end
                    PH_WR_LOW: begin
                        sb = {st.shift_byte[6:0], 1'b0};
                        n.bit_index  = bi;
                        n.shift_byte = sb;
                        if (bi >= LAST_BIT) begin
                            n.phase = PH_IDLE; n.delay_count = '0; done = 1'b1;
                        end else begin
                            n.sda_level   = sb[7];
                            n.delay_count = hold2;
                            n.phase       = PH_WR_SET;
                        end
                    end
                    PH_RD_LOW: begin
                        n.scl_level   = 1'b1;
                        n.shift_byte  = {st.shift_byte[6:0], item.sda_in};
                        n.delay_count = hold1;
                        n.phase       = PH_RD_HIGH;
                    end
                    PH_RD_HIGH: begin
                        n.bit_index   = bi;
                        n.scl_level   = 1'b0;
                        n.delay_count = hold2;
                        if (bi >= LAST_BIT) begin
                            n.last_rd   = st.shift_byte;
                            n.sda_dir   = 1'b1;
                            n.sda_level = !st.ack_choice;
                            n.phase     = PH_AK_LOW;
                        end else begin
                            n.phase = PH_RD_LOW;
                        end
                    end
                    PH_AK_LOW: begin
                        n.scl_level = 1'b1; n.delay_count = hold2; n.phase = PH_AK_HIGH;
                    end
                    PH_AK_HIGH: begin
                        n.scl_level = 1'b0; n.phase = PH_IDLE; done = 1'b1;
                    end
                    PH_WA1: begin
                        n.scl_level = 1'b1; n.delay_count = hold1; n.phase = PH_WA2;
                    end
                    PH_WA2, PH_WA_POLL: begin
                        n.phase       = PH_WA_POLL;
                        n.delay_count = '0;
                        if (!item.sda_in) begin
                            n.scl_level = 1'b0; n.phase = PH_IDLE; done = 1'b1;
                        end else if (st.timeout_count >= cfg.ack_timeout) begin
                            n.miss_flag   = 1'b1;
                            n.sda_dir     = 1'b1;
                            n.scl_level   = 1'b0;
                            n.sda_level   = 1'b0;
                            n.delay_count = hold4;
                            n.phase       = PH_SP1;
                        end else begin
                            n.timeout_count = st.timeout_count + 8'd1;
                        end
                    end
                    default: begin
                        n.phase = PH_IDLE; n.delay_count = '0; done = 1'b1;
                    end
                endcase
            end
        end else if (cmd != FUNC_NONE) begin
            n.miss_flag     = 1'b0;
            n.bit_index     = '0;
            n.timeout_count = '0;
            case (cmd)
                FUNC_START: begin
                    n.sda_dir = 1'b1; n.sda_level = 1'b1; n.scl_level = 1'b1;
                    n.delay_count = hold4; n.phase = PH_ST1;
                end
                FUNC_STOP: begin
                    n.sda_dir = 1'b1; n.scl_level = 1'b0; n.sda_level = 1'b0;
                    n.delay_count = hold4; n.phase = PH_SP1;
                end
                FUNC_WRITE: begin
                    n.shift_byte = item.wr_data;
                    n.sda_dir = 1'b1; n.scl_level = 1'b0;
                    n.sda_level = item.wr_data[7];
                    n.delay_count = hold2; n.phase = PH_WR_SET;
                end
                FUNC_READ: begin
                    n.shift_byte = '0;
                    n.ack_choice = item.send_ack;
                    n.sda_dir = 1'b0; n.scl_level = 1'b0;
                    n.delay_count = hold2; n.phase = PH_RD_LOW;
                end
                default: begin
                    n.sda_dir = 1'b0; n.sda_level = 1'b1;
                    n.delay_count = hold1; n.phase = PH_WA1;
                end
            endcase
        end
    end

    assign st_next         = n;
    assign res.scl_out     = n.scl_level;
    assign res.sda_out     = n.sda_level;
    assign res.sda_drive   = n.sda_dir;
    assign res.busy_res    = (n.phase != PH_IDLE);
    assign res.done_res    = done;
    assign res.rd_data     = n.last_rd;
    assign res.ack_missing = n.miss_flag;
    assign res.cmd_ignored = ignored;

endmodule
